FILE: design/jsu_pkg.sv
// Package for the JSON string unescaper: escape state, request (job) type,
// queue constants and the hex and UTF-8 helper functions.
// No dependencies.
`default_nettype none

package jsu_pkg;

  // Depth of the job queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Characters used by the decoder
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Escape decoder state
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } esc_mode_t;

  // One request in the queue: up to three output bytes, first in data[0]
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            last;
  } job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Hex digit value, anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

  // UTF-8 encoding of a 16-bit code point into one to three bytes
  function automatic job_t utf8_job(input logic [15:0] cp, input logic last);
    job_t j;
    j.last = last;
    j.data = '0;
    if (cp < 16'h0080) begin
      j.cnt     = 2'd1;
      j.data[0] = {1'b0, cp[6:0]};
    end else if (cp < 16'h0800) begin
      j.cnt     = 2'd2;
      j.data[0] = {3'b110, cp[10:6]};
      j.data[1] = {2'b10, cp[5:0]};
    end else begin
      j.cnt     = 2'd3;
      j.data[0] = {4'b1110, cp[15:12]};
      j.data[1] = {2'b10, cp[11:6]};
      j.data[2] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

endpackage

`default_nettype wire

FILE: design/json_string_unescape.sv
// JSON string unescaper top level: front decoder, request queue and back
// serialiser. Each accepted byte's request goes into the 4-entry queue, which
// absorbs bursts; the back loads its bytes into the output register. One input
// byte per cycle while not full, one result byte per cycle while popped.
// Reset (rst_n, synchronous) empties the queue and output, escape state to text.
`default_nettype none

module json_string_unescape import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);

  q_stat_t q_stat;
  job_t    wr_job, rd_job;
  logic    q_push, q_pop;

  jsu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_job   (wr_job)
  );

  jsu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_job (wr_job),
    .rd_en  (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_job          (rd_job),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire

FILE: design/jsu_front.sv
// Front part of the unescaper: accepts input bytes, tracks the escape state
// and turns bytes that release output into queue requests. Depends on jsu_pkg.
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire q_stat_t    q_stat,
  output logic            q_push,
  output job_t            q_job
);

  esc_mode_t   mode_r, mode_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        accept;
  logic [15:0] cp_shift;

  assign full     = q_stat.full;
  assign accept   = push && !q_stat.full;
  assign cp_shift = {cp_r[11:0], hex_value(in_byte)};

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    digits_nxt = digits_r;
    cp_nxt     = cp_r;
    if (accept) begin
      case (mode_r)
        MODE_ESC: begin
          if (in_byte == CH_U) begin
            mode_nxt   = MODE_HEX;
            digits_nxt = 2'd0;
            cp_nxt     = '0;
          end else begin
            mode_nxt = MODE_TEXT;
          end
        end
        MODE_HEX: begin
          if (digits_r == 2'd3) begin
            mode_nxt   = MODE_TEXT;
            digits_nxt = 2'd0;
            cp_nxt     = '0;
          end else begin
            digits_nxt = digits_r + 2'd1;
            cp_nxt     = cp_shift;
          end
        end
        default: begin
          mode_nxt = (in_byte == CH_BSLASH) ? MODE_ESC : MODE_TEXT;
        end
      endcase
      // end of string returns everything to rest
      if (in_last) begin
        mode_nxt   = MODE_TEXT;
        digits_nxt = 2'd0;
        cp_nxt     = '0;
      end
    end
  end

  // Request for the current byte
  always_comb begin
    q_job      = '0;
    q_job.last = in_last;
    case (mode_r)
      MODE_ESC: begin
        q_job.cnt = 2'd1;
        case (in_byte)
          CH_U:      q_job = in_last ? utf8_job(16'd0, 1'b1) : '0;
          CH_QUOTE:  q_job.data[0] = CH_QUOTE;
          CH_BSLASH: q_job.data[0] = CH_BSLASH;
          CH_SLASH:  q_job.data[0] = CH_SLASH;
          CH_B:      q_job.data[0] = CH_BS;
          CH_F:      q_job.data[0] = CH_FF;
          CH_N:      q_job.data[0] = CH_LF;
          CH_R:      q_job.data[0] = CH_CR;
          CH_T:      q_job.data[0] = CH_TAB;
          default: begin
            // unknown escape keeps the backslash
            q_job.cnt     = 2'd2;
            q_job.data[0] = CH_BSLASH;
            q_job.data[1] = in_byte;
          end
        endcase
      end
      MODE_HEX: begin
        if (digits_r == 2'd3 || in_last) q_job = utf8_job(cp_shift, in_last);
      end
      default: begin
        if (in_byte != CH_BSLASH || in_last) begin
          q_job.cnt     = 2'd1;
          q_job.data[0] = in_byte;
        end
      end
    endcase
  end

  assign q_push = accept && (q_job.cnt != 2'd0);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_TEXT;
      digits_r <= 2'd0;
      cp_r     <= '0;
    end else begin
      mode_r   <= mode_nxt;
      digits_r <= digits_nxt;
      cp_r     <= cp_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/jsu_queue.sv
// Short request queue between front and back of the unescaper.
// Depends on jsu_pkg.
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  input  wire logic rd_en,
  output job_t      rd_job,
  output q_stat_t   stat
);

  job_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, rptr_r;
  logic [QCW-1:0]   count_r;
  logic             do_wr, do_rd;

  assign stat.full  = (count_r == QCW'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_job     = mem_r[rptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= wptr_r + QAW'(1);
      if (do_rd) rptr_r <= rptr_r + QAW'(1);
      if (do_wr && !do_rd) count_r <= count_r + QCW'(1);
      else if (do_rd && !do_wr) count_r <= count_r - QCW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/jsu_back.sv
// Back part of the unescaper: walks the bytes of the head request and holds
// each in the output register until popped. Depends on jsu_pkg.
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_stat_t     q_stat,
  input  wire job_t        q_job,
  output logic             q_pop,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_string_end
);

  logic       valid_r;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       run_last_r, string_end_r;
  logic       load, tail;

  // Output register takes a new byte when free or being drained
  assign load  = (!valid_r || pop) && !q_stat.empty;
  assign tail  = (idx_r == q_job.cnt - 2'd1);
  assign q_pop = load && tail;

  always_comb begin
    idx_nxt = idx_r;
    if (load) idx_nxt = tail ? 2'd0 : idx_r + 2'd1;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) valid_r <= 1'b1;
      else if (pop) valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r       <= q_job.data[idx_r];
      run_last_r   <= tail;
      string_end_r <= tail && q_job.last;
    end
  end

  assign empty          = !valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_string_end = string_end_r;

endmodule

`default_nettype wire

FILE: design/jsu_checker.sv
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module jsu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       push,
  input wire logic       full,
  input wire logic       in_last,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_run_last,
  input wire logic       out_string_end
);

  // Reset leaves no result and room for input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("result or full flag after reset");

  // A held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_run_last)
                       && $stable(out_string_end))
    else $error("waiting result changed");

  // End of string is always the last byte of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_string_end |-> out_run_last)
    else $error("string end without run end");

  // A last byte accepted on an idle block passes through the queue into the output
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && in_last && empty && $past(empty) && !$past(push)
    |-> ##2 !empty)
    else $error("last byte gave no result");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .in_last        (in_last),
  .empty          (empty),
  .pop            (pop),
  .out_byte       (out_byte),
  .out_run_last   (out_run_last),
  .out_string_end (out_string_end)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the JSON string unescaper: directed and random escaped strings,
// predicted byte by byte and checked against the result queue of the block.
// Depends on jsu_pkg and json_string_unescape.
`default_nettype none

module tb import jsu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no request moving on either side before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES = 370;
  localparam int HOLD_AT = 120;
  localparam int HOLD_CYCLES = 250;

  localparam logic [7:0] ESC_CHARS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                           CH_F, CH_N, CH_R, CH_T};
  // Bytes that are not hex digits, with the range borders
  localparam logic [7:0] NON_HEX [12] = '{8'h67, 8'h47, 8'h2F, 8'h3A, 8'h40, 8'h5B,
                                          8'h60, 8'h7B, 8'h00, 8'hFF, CH_BSLASH, CH_U};

  // One unescaped output byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } unescaped_byte_t;

  // Scoreboard: own copy of the escape state, predicts and checks
  class unescape_scoreboard;
    esc_mode_t       mode;
    logic [1:0]      digits;
    logic [15:0]     cp;
    logic [7:0]      step_bytes[$];
    unescaped_byte_t expected_bytes[$];
    int              errors;
    int              n_in;
    int              n_strings;
    int              n_checked;

    function new();
      clear_state();
      errors    = 0;
      n_in      = 0;
      n_strings = 0;
      n_checked = 0;
    endfunction

    function void clear_state();
      mode   = MODE_TEXT;
      digits = 2'd0;
      cp     = 16'h0000;
    endfunction

    function logic [3:0] nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
      if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
      return 4'd0;
    endfunction

    // {known, mapped byte} for the one-byte escapes
    function logic [8:0] map_escape(logic [7:0] c);
      case (c)
        CH_QUOTE:  return {1'b1, CH_QUOTE};
        CH_BSLASH: return {1'b1, CH_BSLASH};
        CH_SLASH:  return {1'b1, CH_SLASH};
        CH_B:      return {1'b1, CH_BS};
        CH_F:      return {1'b1, CH_FF};
        CH_N:      return {1'b1, CH_LF};
        CH_R:      return {1'b1, CH_CR};
        CH_T:      return {1'b1, CH_TAB};
        default:   return {1'b0, 8'h00};
      endcase
    endfunction

    // Append one byte to those released by the current input
    function void add_byte(logic [7:0] b);
      step_bytes.insert(step_bytes.size(), b);
    endfunction

    function void put_utf8(logic [15:0] v);
      if (v < 16'h0080) begin
        add_byte({1'b0, v[6:0]});
      end else if (v < 16'h0800) begin
        add_byte({3'b110, v[10:6]});
        add_byte({2'b10, v[5:0]});
      end else begin
        add_byte({4'b1110, v[15:12]});
        add_byte({2'b10, v[11:6]});
        add_byte({2'b10, v[5:0]});
      end
    endfunction

    // Accepted input byte: work out the bytes it releases
    function void note_request(logic [7:0] c, logic last);
      logic [8:0]      esc;
      unescaped_byte_t rec;
      step_bytes.delete();
      n_in++;
      case (mode)
        MODE_ESC: begin
          if (c == CH_U) begin
            mode   = MODE_HEX;
            digits = 2'd0;
            cp     = 16'h0000;
            if (last) put_utf8(16'h0000);
          end else begin
            esc = map_escape(c);
            if (esc[8]) begin
              add_byte(esc[7:0]);
            end else begin
              add_byte(CH_BSLASH);
              add_byte(c);
            end
            mode = MODE_TEXT;
          end
        end
        MODE_HEX: begin
          cp = {cp[11:0], nibble(c)};
          if (digits == 2'd3) begin
            put_utf8(cp);
            mode   = MODE_TEXT;
            digits = 2'd0;
            cp     = 16'h0000;
          end else begin
            digits = digits + 2'd1;
            if (last) put_utf8(cp);
          end
        end
        default: begin
          // plain text, and the unused mode value
          if (c == CH_BSLASH) begin
            mode = MODE_ESC;
            if (last) add_byte(CH_BSLASH);
          end else begin
            mode = MODE_TEXT;
            add_byte(c);
          end
        end
      endcase
      foreach (step_bytes[i]) begin
        rec.data       = step_bytes[i];
        rec.run_last   = (i == step_bytes.size() - 1);
        rec.string_end = last && (i == step_bytes.size() - 1);
        expected_bytes.insert(expected_bytes.size(), rec);
      end
      if (last) begin
        clear_state();
        n_strings++;
      end
    endfunction

    // Accepted result: compare with the oldest expected byte
    function void check_result(logic [7:0] b, logic rl, logic se);
      unescaped_byte_t want;
      n_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result out_byte %h run_last %b string_end %b", b, rl, se);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.data) begin
        $error("out_byte expected %h actual %h", want.data, b);
        errors++;
      end
      if (rl !== want.run_last) begin
        $error("out_run_last expected %b actual %b", want.run_last, rl);
        errors++;
      end
      if (se !== want.string_end) begin
        $error("out_string_end expected %b actual %b", want.string_end, se);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  unescape_scoreboard sb = new();
  logic [7:0] text_q[$];
  bit         in_calm = 1'b0;
  int         quiet = 0;

  json_string_unescape i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) calm = !calm;
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    foreach (ESC_CHARS[i])
      if (ESC_CHARS[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // Append one byte to the string being built
  function automatic void append_text(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // Code point spread over the one, two and three byte encodings
  function automatic logic [15:0] pick_code_point();
    logic [15:0] borders [8];
    borders = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
                16'hD800, 16'hDFFF};
    case ($urandom_range(0, 9))
      0:       return borders[$urandom_range(0, 7)];
      1, 2, 3: return 16'($urandom_range(0, 16'h007F));
      4, 5, 6: return 16'($urandom_range(16'h0080, 16'h07FF));
      default: return 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  function automatic void add_unicode();
    logic [15:0] v;
    v = pick_code_point();
    append_text(CH_BSLASH);
    append_text(CH_U);
    for (int i = 3; i >= 0; i--) begin
      if ($urandom_range(0, 99) < 6) append_text(NON_HEX[$urandom_range(0, 11)]);
      else append_text(hex_char(v[4*i +: 4]));
    end
  endfunction

  // One random string: mostly well-formed escapes, some noise and cut-off tails
  function automatic void build_text();
    int         ntok;
    int         kind;
    int         nd;
    logic [7:0] c;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      ntok = $urandom_range(1, 10);
      repeat (ntok) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) c = CH_BSLASH;
        else if (kind < 3) c = CH_U;
        else if (kind < 4) c = NON_HEX[$urandom_range(0, 11)];
        else c = 8'($urandom);
        append_text(c);
      end
      return;
    end
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        c = 8'($urandom);
        if (c == CH_BSLASH) c = 8'h41;
        append_text(c);
      end else if (kind < 65) begin
        append_text(CH_BSLASH);
        append_text(ESC_CHARS[$urandom_range(0, 7)]);
      end else if (kind < 72) begin
        c = 8'($urandom);
        if (is_escape_char(c) || c == CH_U) c = 8'h71;
        append_text(CH_BSLASH);
        append_text(c);
      end else begin
        add_unicode();
      end
    end
    // string cut off inside an escape
    if ($urandom_range(0, 5) == 0) begin
      nd = $urandom_range(0, 4);
      append_text(CH_BSLASH);
      if (nd > 0) begin
        append_text(CH_U);
        repeat (nd - 1) append_text(hex_char(4'($urandom)));
      end
    end
  endfunction

  task automatic idle_in(input int n);
    if (n > 0) begin
      push    <= 1'b0;
      in_byte <= 8'($urandom);
      in_last <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    push    <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (full);
    sb.note_request(b, l);
  endtask

  // Send text_q as one string, last marker on its final byte
  task automatic send_text();
    foreach (text_q[i]) begin
      idle_in(pick_gap(in_calm));
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) append_text(s[i]);
    send_text();
  endtask

  // Watchdog on cycles in which no request moves
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL json_string_unescape");
      $finish;
    end
  end

  // Result side: random pop gaps and one long hold-off to fill the block
  initial begin : drain
    int n;
    int got;
    bit calm;
    bit held;
    got  = 0;
    calm = 1'b0;
    held = 1'b0;
    pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && got == HOLD_AT) begin
        held = 1'b1;
        n    = HOLD_CYCLES;
      end else begin
        n = pick_gap(calm);
      end
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_byte, out_run_last, out_string_end);
      got++;
    end
  end

  // Input side and end of run
  initial begin : stimulus
    int n_rand;
    n_rand = 0;
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_byte <= 8'h00;
    in_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, plain pass-through
    send_byte(8'h00, 1'b0);
    idle_in(pick_gap(in_calm));
    send_byte(8'hFF, 1'b1);
    // every one-byte escape
    send_str("\\n\\\"\\\\\\/\\b\\f\\r\\t");
    // unknown escape, then a surrogate with a non-hex digit
    send_str("\\q\\uD8zF");
    // lone backslash at the end
    send_str("\\");
    // string ends on the u
    send_str("\\u");
    // string ends after two hex digits, two-byte result
    send_str("\\uAB");

    while (n_rand < RANDOM_BYTES) begin
      build_text();
      send_text();
      n_rand += text_q.size();
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input bytes in %0d strings and %0d result bytes checked,",
             sb.n_in, sb.n_strings, sb.n_checked);
    $display("with all escapes, \\u forms, cut-off strings and a full-queue stall.");
    if (sb.errors == 0) $display("PASS json_string_unescape");
    else $display("FAIL json_string_unescape");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape.sv
design/jsu_checker.sv
tb/sv/tb.sv
